// ----- rtl/tal_pkg.sv -----
package tal_pkg;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned TEMP_W    = 8;
  localparam int unsigned OFFSET_W  = 6;
  localparam int unsigned RES_COUNT = 70;

  // adc code thresholds, one per degree from 0 C, descending
  localparam logic [SAMPLE_W-1:0] THRESHOLDS [RES_COUNT] = '{
    12'd1809, 12'd1778, 12'd1748, 12'd1718, 12'd1689,
    12'd1657, 12'd1629, 12'd1602, 12'd1576, 12'd1550,
    12'd1522, 12'd1498, 12'd1474, 12'd1451, 12'd1429,
    12'd1405, 12'd1384, 12'd1363, 12'd1343, 12'd1324,
    12'd1304, 12'd1285, 12'd1268, 12'd1251, 12'd1234,
    12'd1218, 12'd1203, 12'd1188, 12'd1173, 12'd1159,
    12'd1142, 12'd1128, 12'd1115, 12'd1103, 12'd1091,
    12'd1078, 12'd1067, 12'd1056, 12'd1045, 12'd1035,
    12'd1025, 12'd1015, 12'd1006, 12'd997,  12'd988,
    12'd980,  12'd972,  12'd964,  12'd956,  12'd949,
    12'd942,  12'd935,  12'd928,  12'd922,  12'd916,
    12'd910,  12'd904,  12'd899,  12'd893,  12'd888,
    12'd883,  12'd878,  12'd874,  12'd869,  12'd865,
    12'd860,  12'd856,  12'd852,  12'd848,  12'd845
  };

  typedef logic [SUM_W-1:0] scaled_tab_t [RES_COUNT];

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } tal_cmd_t;

  typedef struct packed {
    logic avg_due;
    logic hit;
    logic last;
  } tal_sts_t;

  // thresholds in units of the sample sum, so no divide is needed
  function automatic scaled_tab_t scale_table(int unsigned samples);
    scaled_tab_t tab;
    for (int i = 0; i < RES_COUNT; i++) begin
      tab[i] = SUM_W'(32'(THRESHOLDS[i]) * samples);
    end
    return tab;
  endfunction

endpackage

// ----- rtl/tal_ctrl.sv -----
module tal_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tal_pkg::tal_sts_t sts_i,
  output tal_pkg::tal_cmd_t cmd_o
);
  import tal_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;
  logic scan_end;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign scan_end   = sts_i.hit || sts_i.last;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.avg_due) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          if (slot_free) begin
            cmd_o.finish = 1'b1;
            out_valid_d  = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result written over a pending transaction");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o)
    else $error("finished scan did not raise out_valid");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.step, cmd_o.finish}))
    else $error("overlapping datapath commands");

endmodule

// ----- rtl/tal_datapath.sv -----
module tal_datapath #(
  parameter int unsigned TABLE_ENTRIES       = 70,
  parameter int unsigned SAMPLES_PER_AVERAGE = 10
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [tal_pkg::SAMPLE_W-1:0]             adc_sample_i,
  input  logic                                     cfg_valid_i,
  input  logic signed [tal_pkg::OFFSET_W-1:0]      correction_offset_i,
  input  tal_pkg::tal_cmd_t                        cmd_i,
  output tal_pkg::tal_sts_t                        sts_o,
  output logic signed [tal_pkg::TEMP_W-1:0]        temperature_o,
  output logic                                     out_of_range_o
);
  import tal_pkg::*;

  localparam int unsigned ScanLen =
    (TABLE_ENTRIES < RES_COUNT) ? TABLE_ENTRIES : RES_COUNT;
  localparam int unsigned IdxW = $clog2(ScanLen);
  localparam int unsigned CntW =
    (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
  localparam scaled_tab_t ScaledThr = scale_table(SAMPLES_PER_AVERAGE);

  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [OFFSET_W-1:0] offset_q;
  logic [TEMP_W-1:0]   held_q, held_d;
  logic                oor_q, oor_d;
  logic [TEMP_W-1:0]   new_temp;

  assign sts_o.avg_due = (count_q == CntW'(SAMPLES_PER_AVERAGE - 1));
  assign sts_o.hit     = (sum_q >= ScaledThr[idx_q]);
  assign sts_o.last    = (idx_q == IdxW'(ScanLen - 1));

  assign new_temp = TEMP_W'(idx_q)
                  + {{(TEMP_W - OFFSET_W){offset_q[OFFSET_W-1]}}, offset_q};

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    idx_d   = idx_q;
    held_d  = held_q;
    oor_d   = oor_q;
    if (cmd_i.accept) begin
      sum_d   = sum_q + SUM_W'(adc_sample_i);
      count_d = sts_o.avg_due ? '0 : count_q + CntW'(1);
    end
    if (cmd_i.step) begin
      idx_d = idx_q + IdxW'(1);
    end
    if (cmd_i.finish) begin
      sum_d = '0;
      idx_d = '0;
      oor_d = !sts_o.hit;
      if (sts_o.hit) begin
        held_d = new_temp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      held_q   <= '0;
      oor_q    <= 1'b0;
      offset_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      held_q  <= held_d;
      oor_q   <= oor_d;
      if (cfg_valid_i) begin
        offset_q <= correction_offset_i;
      end
    end
  end

  assign temperature_o  = held_q;
  assign out_of_range_o = oor_q;

  a_step_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !sts_o.last)
    else $error("scan index stepped past the table");

  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (sum_q == '0 && idx_q == '0))
    else $error("sum or index not cleared after scan");

endmodule

// ----- rtl/thermistor_average_lookup.sv -----
// Thermistor temperature lookup. Each accepted transaction carries one 12-bit
// converter code from the NTC divider; samples are summed, and every
// SAMPLES_PER_AVERAGE-th sample closes a block, whose truncated average is
// matched against a descending threshold table of one entry per degree from
// 0 C (min(TABLE_ENTRIES, 70) entries). The first entry met or exceeded gives
// the index, correction_offset is added, and one result transaction is sent
// with out_of_range low; if no entry matches, the last good temperature is
// repeated with out_of_range high. Other samples produce no result. A sample
// that does not close a block leaves the input ready for the next sample. A
// closing sample starts a scan, in which the single threshold comparator steps
// through the table one entry at a time, and no sample is taken while it runs.
// The result waits in an output register, and a finished scan stalls only
// while that register still holds an untaken result. correction_offset is
// written through the cfg channel, which is always ready.
module thermistor_average_lookup #(
  parameter int unsigned TABLE_ENTRIES       = 70,
  parameter int unsigned SAMPLES_PER_AVERAGE = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tal_pkg::SAMPLE_W-1:0]        adc_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tal_pkg::TEMP_W-1:0]   temperature_o,
  output logic                                out_of_range_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic signed [tal_pkg::OFFSET_W-1:0] correction_offset_i
);
  import tal_pkg::*;

  tal_cmd_t cmd;
  tal_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tal_datapath #(
    .TABLE_ENTRIES       (TABLE_ENTRIES),
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .adc_sample_i        (adc_sample_i),
    .cfg_valid_i         (cfg_valid_i),
    .correction_offset_i (correction_offset_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .temperature_o       (temperature_o),
    .out_of_range_o      (out_of_range_o)
  );

endmodule
